/* rtl/rsgdt_pkg.sv */
// ----------------------------------------------------------------------------
// Range sum table package
// Shared widths, operation codes and state encodings of the range sum table.
// ----------------------------------------------------------------------------
package rsgdt_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int VALUE_W       = 32;
  localparam int RESULT_W      = 42;
  localparam int FUNC_W        = 2;
  localparam int INDEX_W       = 10;
  localparam int END_W         = 11;
  localparam int IN_TDATA_W    = 112;
  localparam int OUT_TDATA_W   = 48;

  localparam logic [RESULT_W-1:0] RESULT_MAX = {RESULT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_SUM   = 2'd1,
    FUNC_DRAIN = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_RESP  = 4'b1000
  } state_e;

endpackage

/* rtl/range_sum_greedy_drain_table_core.sv */
// ----------------------------------------------------------------------------
// Range sum table with greedy drain
// Holds DEPTH 32-bit quantities and serves loads, range sums and drains.
// ----------------------------------------------------------------------------
// After reset the block clears its entry memory, one entry a cycle, during which
// no transfer is accepted. A load passes through ST_RESP to the result register.
// A range sum or a drain walks the entries of the clamped range through the
// single read port of the memory, one entry a cycle; a drain stops early once
// the requested amount has been taken. Drained entries are written back in the
// cycle after their read, so the walk never meets its own writes.
module range_sum_greedy_drain_table_core #(
  parameter int DEPTH = rsgdt_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // entry_index, load_value, range_start, range_end, direction, amount
  input  logic [rsgdt_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // func
  input  logic [rsgdt_pkg::FUNC_W-1:0]       s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // result
  output logic [rsgdt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W > rsgdt_pkg::END_W) ? CNT_W : rsgdt_pkg::END_W;
  localparam int SUM_W = rsgdt_pkg::VALUE_W + AW;
  localparam int CMP_W = (SUM_W > rsgdt_pkg::RESULT_W) ? SUM_W : rsgdt_pkg::RESULT_W;
  localparam int VW    = rsgdt_pkg::VALUE_W;
  localparam int RW    = rsgdt_pkg::RESULT_W;

  rsgdt_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]  clr_q, clr_d;
  logic              drain_q, drain_d;
  logic              dir_q, dir_d;
  logic [RW-1:0]     amt_q, amt_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [EXT_W-1:0]  ptr_q, ptr_d;
  logic [EXT_W-1:0]  left_q, left_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [RW-1:0]     res_q, res_d;
  logic              m_valid_q, m_valid_d;
  logic [RW-1:0]     m_data_q, m_data_d;

  rsgdt_pkg::func_e  in_func;
  logic [EXT_W-1:0]  in_idx, in_lo, in_end, in_hi;
  logic [VW-1:0]     in_val;
  logic              in_dir;
  logic [RW-1:0]     in_amt;
  logic              accept;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [VW-1:0]     mem_wdata;
  logic [VW-1:0]     mem_rdata;

  logic [RW-1:0]     data_ext, take;
  logic              issue;
  logic [CMP_W-1:0]  acc_ext;
  logic [RW-1:0]     sum_sat;

  assign in_func = rsgdt_pkg::func_e'(s_axis_tuser_i);
  assign in_idx  = EXT_W'(s_axis_tdata_i[9:0]);
  assign in_val  = s_axis_tdata_i[41:10];
  assign in_lo   = EXT_W'(s_axis_tdata_i[51:42]);
  assign in_end  = EXT_W'(s_axis_tdata_i[62:52]);
  assign in_dir  = s_axis_tdata_i[63];
  assign in_amt  = s_axis_tdata_i[105:64];
  assign in_hi   = (in_end > EXT_W'(DEPTH)) ? EXT_W'(DEPTH) : in_end;

  assign s_axis_tready_o = (state_q == rsgdt_pkg::ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = rsgdt_pkg::OUT_TDATA_W'(m_data_q);

  assign data_ext = RW'(mem_rdata);
  assign take     = (data_ext < rem_q) ? data_ext : rem_q;
  assign issue    = (left_q != '0) && !(drain_q && (rem_q == '0));
  assign acc_ext  = CMP_W'(acc_q);
  assign sum_sat  = (acc_ext > CMP_W'(rsgdt_pkg::RESULT_MAX)) ? rsgdt_pkg::RESULT_MAX
                                                              : acc_ext[RW-1:0];

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    drain_d   = drain_q;
    dir_d     = dir_q;
    amt_d     = amt_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    ptr_d     = ptr_q;
    left_d    = left_q;
    rd_vld_d  = 1'b0;
    rd_addr_d = rd_addr_q;
    res_d     = res_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q[AW-1:0];
    mem_wdata = '0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      rsgdt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q[AW-1:0];
        clr_d     = clr_q + CNT_W'(1);
        if (clr_q == CNT_W'(DEPTH - 1)) begin
          state_d = rsgdt_pkg::ST_IDLE;
        end
      end
      rsgdt_pkg::ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          drain_d = (in_func == rsgdt_pkg::FUNC_DRAIN);
          dir_d   = in_dir;
          amt_d   = in_amt;
          rem_d   = in_amt;
          acc_d   = '0;
          ptr_d   = in_dir ? (in_hi - EXT_W'(1)) : in_lo;
          left_d  = in_hi - in_lo;
          state_d = rsgdt_pkg::ST_RESP;
          if (in_func == rsgdt_pkg::FUNC_LOAD) begin
            if (in_idx < EXT_W'(DEPTH)) begin
              mem_we    = 1'b1;
              mem_waddr = in_idx[AW-1:0];
              mem_wdata = in_val;
            end
          end else if ((in_func == rsgdt_pkg::FUNC_SUM ||
                        in_func == rsgdt_pkg::FUNC_DRAIN) && (in_lo < in_hi)) begin
            state_d = rsgdt_pkg::ST_SCAN;
          end
        end
      end
      rsgdt_pkg::ST_SCAN: begin
        if (issue) begin
          rd_vld_d  = 1'b1;
          rd_addr_d = ptr_q[AW-1:0];
          ptr_d     = dir_q ? (ptr_q - EXT_W'(1)) : (ptr_q + EXT_W'(1));
          left_d    = left_q - EXT_W'(1);
        end
        if (rd_vld_q) begin
          if (drain_q) begin
            rem_d     = rem_q - take;
            mem_we    = 1'b1;
            mem_waddr = rd_addr_q;
            mem_wdata = mem_rdata - take[VW-1:0];
          end else begin
            acc_d = acc_q + SUM_W'(mem_rdata);
          end
        end
        if (!rd_vld_q && !issue) begin
          res_d   = drain_q ? (amt_q - rem_q) : sum_sat;
          state_d = rsgdt_pkg::ST_RESP;
        end
      end
      rsgdt_pkg::ST_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
          state_d   = rsgdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rsgdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsgdt_pkg::ST_CLEAR;
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drain_q   <= drain_d;
    dir_q     <= dir_d;
    amt_q     <= amt_d;
    rem_q     <= rem_d;
    acc_q     <= acc_d;
    ptr_q     <= ptr_d;
    left_q    <= left_d;
    rd_addr_q <= rd_addr_d;
    res_q     <= res_d;
    m_data_q  <= m_data_d;
  end

  rsgdt_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW),
    .DATA_W (VW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

endmodule

/* rtl/rsgdt_mem.sv */
// ----------------------------------------------------------------------------
// Range sum table entry memory
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module rsgdt_mem #(
  parameter int DEPTH  = rsgdt_pkg::DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = rsgdt_pkg::VALUE_W
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* tb/range_sum_greedy_drain_table_core_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum table checker
// Watches both streams, keeps a flat copy of the table, works out the result
// of every accepted command and compares it with the result transfers.
// ----------------------------------------------------------------------------
module range_sum_greedy_drain_table_core_check #(
  parameter int DEPTH = rsgdt_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  input  logic                              s_ready_i,
  input  logic [rsgdt_pkg::IN_TDATA_W-1:0]  s_data_i,
  input  logic [rsgdt_pkg::FUNC_W-1:0]      s_user_i,
  input  logic                              m_valid_i,
  input  logic                              m_ready_i,
  input  logic [rsgdt_pkg::OUT_TDATA_W-1:0] m_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  logic [31:0] entries [DEPTH];
  logic [rsgdt_pkg::RESULT_W-1:0] expected_results [$];

  function automatic logic [rsgdt_pkg::RESULT_W-1:0] command_result(
      logic [rsgdt_pkg::IN_TDATA_W-1:0] d, rsgdt_pkg::func_e f);
    int idx;
    logic [31:0] val;
    int lo;
    int hi;
    logic dir;
    logic [63:0] amt;
    logic [63:0] total;
    logic [63:0] part;
    int k;
    int pos;
    idx   = int'(d[9:0]);
    val   = d[41:10];
    lo    = int'(d[51:42]);
    hi    = int'(d[62:52]);
    dir   = d[63];
    amt   = {22'd0, d[105:64]};
    total = '0;
    if (hi > DEPTH) hi = DEPTH;
    case (f)
      rsgdt_pkg::FUNC_LOAD: begin
        if (idx < DEPTH) entries[idx] = val;
      end
      rsgdt_pkg::FUNC_SUM: begin
        for (k = lo; k < hi; k++) total += 64'(entries[k]);
        if (total > {22'd0, rsgdt_pkg::RESULT_MAX}) total = {22'd0, rsgdt_pkg::RESULT_MAX};
      end
      rsgdt_pkg::FUNC_DRAIN: begin
        for (k = 0; k < hi - lo; k++) begin
          pos = dir ? hi - 1 - k : lo + k;
          part = (64'(entries[pos]) < amt - total) ? 64'(entries[pos]) : amt - total;
          entries[pos] = entries[pos] - part[31:0];
          total += part;
        end
      end
      default: ;
    endcase
    return total[rsgdt_pkg::RESULT_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
      expected_results.delete();
      for (int i = 0; i < DEPTH; i++) entries[i] = '0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %0d",
                   $time, m_data_i[rsgdt_pkg::RESULT_W-1:0]);
          fail_count_o <= fail_count_o + 1;
        end else if (expected_results[0] !== m_data_i[rsgdt_pkg::RESULT_W-1:0]) begin
          $display("%0t: result wrong, expected %0d, actual %0d",
                   $time, expected_results[0], m_data_i[rsgdt_pkg::RESULT_W-1:0]);
          fail_count_o <= fail_count_o + 1;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (s_valid_i && s_ready_i)
        expected_results.insert(expected_results.size(),
                                command_result(s_data_i, rsgdt_pkg::func_e'(s_user_i)));
      pending_o <= expected_results.size();
    end
  end

endmodule

/* tb/range_sum_greedy_drain_table_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum table testbench
// Loads, sums, drains and no-op commands with directed corner cases and random
// traffic, random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module range_sum_greedy_drain_table_core_test;

  localparam int DEPTH = rsgdt_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 10000000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_valid = 1'b0;
  logic                              s_ready;
  logic [rsgdt_pkg::IN_TDATA_W-1:0]  s_data = '0;
  logic [rsgdt_pkg::FUNC_W-1:0]      s_user = rsgdt_pkg::FUNC_LOAD;
  logic                              m_valid;
  logic                              m_ready = 1'b0;
  logic [rsgdt_pkg::OUT_TDATA_W-1:0] m_data;
  int                                fail_count;
  int                                pending;
  int                                cycle_count = 0;
  logic                              hold_off = 1'b0;

  always #2 clk_i = ~clk_i;

  range_sum_greedy_drain_table_core #(.DEPTH(DEPTH)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data)
  );

  range_sum_greedy_drain_table_core_check #(.DEPTH(DEPTH)) checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  task automatic send_command(rsgdt_pkg::func_e f, logic [9:0] idx, logic [31:0] val,
                              logic [9:0] lo, logic [10:0] hi, logic dir,
                              logic [41:0] amt);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= f;
    s_data  <= {6'd0, amt, dir, hi, lo, val, idx};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic random_command();
    int pick;
    rsgdt_pkg::func_e f;
    logic [9:0] idx;
    logic [9:0] lo;
    logic [10:0] hi;
    logic [31:0] val;
    logic [41:0] amt;
    logic dir;
    pick = $urandom_range(0, 99);
    lo = 10'($urandom_range(0, 1023));
    hi = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                     : 11'(lo + $urandom_range(0, 24));
    idx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'(lo + $urandom_range(0, 24));
    val = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1000);
    amt = ($urandom_range(0, 5) == 0) ? {10'($urandom_range(0, 1023)), $urandom}
                                      : 42'($urandom_range(0, 20000));
    dir = 1'($urandom);
    if (pick < 40)
      f = rsgdt_pkg::FUNC_LOAD;
    else if (pick < 65)
      f = rsgdt_pkg::FUNC_SUM;
    else if (pick < 97)
      f = rsgdt_pkg::FUNC_DRAIN;
    else
      f = rsgdt_pkg::FUNC_NONE;
    send_command(f, idx, val, lo, hi, dir, amt);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("range_sum_greedy_drain_table_core: mismatch");
      $finish;
    end
  end

  initial begin : output_side
    int wait_cycles;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_ready <= 1'b0;
        @(posedge clk_i);
      end else begin
        wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
        if (wait_cycles > 0) begin
          m_ready <= 1'b0;
          repeat (wait_cycles) @(posedge clk_i);
        end
        m_ready <= 1'b1;
        @(posedge clk_i);
        while (!m_valid && !hold_off) @(posedge clk_i);
      end
    end
  end

  initial begin : stall_window
    wait (cycle_count == 5000);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_command(rsgdt_pkg::FUNC_SUM, 10'd0, 32'd0, 10'd0, 11'd1024, 1'b0,
                 42'h3FF_FFFF_FFFF);
    send_command(rsgdt_pkg::FUNC_LOAD, 10'd0, 32'hFFFF_FFFF, 10'd0, 11'd0, 1'b0, 42'd0);
    send_command(rsgdt_pkg::FUNC_LOAD, 10'd1023, 32'hFFFF_FFFF, 10'd0, 11'd0, 1'b0, 42'd0);
    send_command(rsgdt_pkg::FUNC_LOAD, 10'd5, 32'd100, 10'd0, 11'd0, 1'b0, 42'd0);
    send_command(rsgdt_pkg::FUNC_LOAD, 10'd6, 32'd50, 10'd0, 11'd0, 1'b0, 42'd0);
    for (int i = 100; i < 110; i++)
      send_command(rsgdt_pkg::FUNC_LOAD, 10'(i), 32'hFFFF_FFFF, 10'd0, 11'd0, 1'b0, 42'd0);
    send_command(rsgdt_pkg::FUNC_SUM, 10'd0, 32'd0, 10'd0, 11'd2047, 1'b0, 42'd0);
    send_command(rsgdt_pkg::FUNC_SUM, 10'd0, 32'd0, 10'd7, 11'd7, 1'b0, 42'd0);
    send_command(rsgdt_pkg::FUNC_SUM, 10'd0, 32'd0, 10'd9, 11'd3, 1'b0, 42'd0);
    send_command(rsgdt_pkg::FUNC_DRAIN, 10'd0, 32'd0, 10'd0, 11'd10, 1'b0, 42'd0);
    send_command(rsgdt_pkg::FUNC_DRAIN, 10'd0, 32'd0, 10'd0, 11'd10, 1'b0, 42'd120);
    send_command(rsgdt_pkg::FUNC_DRAIN, 10'd0, 32'd0, 10'd0, 11'd2047, 1'b1,
                 42'h3FF_FFFF_FFFF);
    send_command(rsgdt_pkg::FUNC_NONE, 10'h3FF, 32'hFFFF_FFFF, 10'h3FF, 11'h7FF, 1'b1,
                 42'h3FF_FFFF_FFFF);
    send_command(rsgdt_pkg::FUNC_SUM, 10'd0, 32'd0, 10'd0, 11'd1024, 1'b1, 42'd0);
    send_command(rsgdt_pkg::FUNC_DRAIN, 10'd0, 32'd0, 10'd4, 11'd4, 1'b1, 42'd5);
    repeat (1900) random_command();
    send_command(rsgdt_pkg::FUNC_SUM, 10'd0, 32'd0, 10'd0, 11'd1024, 1'b0, 42'd0);
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2200) @(posedge clk_i);
    if (fail_count == 0)
      $display("range_sum_greedy_drain_table_core: match");
    else
      $display("range_sum_greedy_drain_table_core: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/rsgdt_pkg.sv
rtl/rsgdt_mem.sv
rtl/range_sum_greedy_drain_table_core.sv
tb/range_sum_greedy_drain_table_core_check.sv
tb/range_sum_greedy_drain_table_core_test.sv
